// ===== rtl/core/ckcp_pkg.sv =====
// Package for the chroma key compositing block: pixel types, register indexes
// and the elaboration-time construction of the sigmoid alpha table.
// No dependencies.
package ckcp_pkg;

  localparam int SigTableEntries = 256;
  localparam int AlphaFracBits   = 10;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgKeyBlue   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyGreen  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyRed    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlueGain  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAlphaScale = 3'd4;

  localparam logic [7:0]  KeyBlueRst    = 8'd0;
  localparam logic [7:0]  KeyGreenRst   = 8'd255;
  localparam logic [7:0]  KeyRedRst     = 8'd0;
  localparam logic [9:0]  BlueGainRst   = 10'd325;
  localparam logic [15:0] AlphaScaleRst = 16'd257;

  localparam logic [63:0] Q31One = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [7:0] fg_blue;
    logic [7:0] fg_green;
    logic [7:0] fg_red;
    logic [7:0] bg_blue;
    logic [7:0] bg_green;
    logic [7:0] bg_red;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } pix_out_t;

  // Restoring division by shift and subtract, used only for constants.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-u) in Q.31 by a Taylor series at u/16 followed by four squarings.
  function automatic logic [63:0] exp_neg_q31(logic [63:0] u);
    logic [63:0]        v;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        y;
    v    = u >> 4;
    term = Q31One;
    sum  = $signed(Q31One);
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * v) >> 31, 64'(k));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(Q31One)) begin
      sum = $signed(Q31One);
    end
    y = $unsigned(sum);
    for (int k = 0; k < 4; k++) begin
      y = (y * y) >> 31;
    end
    return y;
  endfunction

  // Entry i of an n-entry sigmoid table with f fraction bits.
  function automatic logic [31:0] sig_entry(int n, int f, int i);
    logic signed [63:0] s;
    logic [63:0]        mag;
    logic [63:0]        u;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    s   = 64'(2 * i + 1 - n);
    mag = (s < 0) ? $unsigned(-s) : $unsigned(s);
    u   = udiv64(mag * 64'd20 * Q31One, 64'(2 * n));
    e   = exp_neg_q31(u);
    num = (s >= 0) ? Q31One : e;
    den = Q31One + e;
    return 32'(udiv64((num << f) + (den >> 1), den));
  endfunction

endpackage

// ===== rtl/core/ckcp_intf.sv =====
// Valid/ready channel interfaces for the chroma key compositing block.
// Depends on ckcp_pkg for the pixel payload types.
interface ckcp_in_if;
  logic              valid;
  logic              ready;
  ckcp_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ckcp_out_if;
  logic               valid;
  logic               ready;
  ckcp_pkg::pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/chroma_key_composite_pixel.sv =====
// Top level of the chroma key compositor: configuration registers and the
// six-stage compositing pipeline. Depends on ckcp_pkg and ckcp_intf.
//
// The block takes one foreground and background pixel pair per clock while the
// output is not stalled, and returns the composited pixel once it has passed the
// pipeline registers in order: the key difference multiply, the alpha scale
// multiply, the table index, the sigmoid table read, the per-channel blend
// multiply and the round and saturate stage each take one register stage.
// Backpressure stalls only the stages that hold data, so bubbles are squeezed
// out. The sigmoid table is constant logic built at elaboration. Registers should
// be written only while no pixel is in flight.
module chroma_key_composite_pixel #(
  parameter int SIGMOID_TABLE_ENTRIES = ckcp_pkg::SigTableEntries,
  parameter int ALPHA_FRACTION_BITS   = ckcp_pkg::AlphaFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ckcp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ckcp_pkg::CfgDataW-1:0] cfg_wdata_i,
  ckcp_in_if.sink                       pix_in_i,
  ckcp_out_if.source                    pix_out_o
);

  localparam int N    = SIGMOID_TABLE_ENTRIES;
  localparam int F    = ALPHA_FRACTION_BITS;
  localparam int IdxW = $clog2(N);
  localparam int SigW = F + 1;
  localparam int VW   = F + 11;
  localparam logic [SigW-1:0]       One  = SigW'(1) << F;
  localparam logic signed [VW-1:0]  Half = VW'(1) << (F - 1);

  logic [7:0]  key_blue_q, key_green_q, key_red_q;
  logic [9:0]  blue_gain_q;
  logic [15:0] alpha_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_blue_q    <= ckcp_pkg::KeyBlueRst;
      key_green_q   <= ckcp_pkg::KeyGreenRst;
      key_red_q     <= ckcp_pkg::KeyRedRst;
      blue_gain_q   <= ckcp_pkg::BlueGainRst;
      alpha_scale_q <= ckcp_pkg::AlphaScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ckcp_pkg::CfgKeyBlue:    key_blue_q    <= cfg_wdata_i[7:0];
        ckcp_pkg::CfgKeyGreen:   key_green_q   <= cfg_wdata_i[7:0];
        ckcp_pkg::CfgKeyRed:     key_red_q     <= cfg_wdata_i[7:0];
        ckcp_pkg::CfgBlueGain:   blue_gain_q   <= cfg_wdata_i[9:0];
        ckcp_pkg::CfgAlphaScale: alpha_scale_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [SigW-1:0] sig_rom [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_sig_rom
    assign sig_rom[gi] = SigW'(ckcp_pkg::sig_entry(N, F, gi));
  end

  logic [6:1] vld_q;
  logic [6:1] en;

  always_comb begin
    en[6] = !vld_q[6] || pix_out_o.ready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pix_in_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= pix_in_i.valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: key difference d = min(key_green, green) * 256 - gain * blue.
  ckcp_pkg::pix_in_t  pix1_q, pix2_q, pix3_q, pix4_q;
  logic signed [18:0] d1_d, d1_q;
  logic [7:0]         gmin;

  always_comb begin
    gmin = (pix_in_i.data.fg_green < key_green_q) ? pix_in_i.data.fg_green : key_green_q;
    d1_d = $signed({3'b000, gmin, 8'h00})
         - $signed({1'b0, 18'(blue_gain_q) * 18'(pix_in_i.data.fg_blue)});
  end

  // Stage 2: scaled difference.
  logic signed [35:0] prod2_d, prod2_q;

  assign prod2_d = $signed({1'b0, alpha_scale_q}) * d1_q;

  // Stage 3: round to Q.12, raw alpha, table index.
  logic signed [35:0] t3;
  logic signed [23:0] t12;
  logic signed [24:0] raw3;
  logic [31:0]        idx_full;
  logic [IdxW-1:0]    idx3_d, idx3_q;

  always_comb begin
    t3       = prod2_q + 36'sd2048;
    t12      = 24'(t3 >>> 12);
    raw3     = 25'sd4096 - 25'(t12);
    idx_full = (32'(raw3[11:0]) * 32'(N)) >> 12;
    if (raw3[24]) begin
      idx3_d = '0;
    end else if (|raw3[23:12]) begin
      idx3_d = IdxW'(N - 1);
    end else begin
      idx3_d = idx_full[IdxW-1:0];
    end
  end

  // Stage 4: one minus alpha from the sigmoid table.
  logic [SigW-1:0] om4_d, om4_q;

  assign om4_d = One - sig_rom[idx3_q];

  // Stage 5: per-channel blend sum.
  logic [7:0]         fgc [3];
  logic [7:0]         bgc [3];
  logic [7:0]         keyc [3];
  logic signed [8:0]  diff5 [3];
  logic signed [VW-1:0] v5_d [3];
  logic signed [VW-1:0] v5_q [3];

  always_comb begin
    fgc[0]  = pix4_q.fg_blue;
    fgc[1]  = pix4_q.fg_green;
    fgc[2]  = pix4_q.fg_red;
    bgc[0]  = pix4_q.bg_blue;
    bgc[1]  = pix4_q.bg_green;
    bgc[2]  = pix4_q.bg_red;
    keyc[0] = key_blue_q;
    keyc[1] = key_green_q;
    keyc[2] = key_red_q;
    for (int c = 0; c < 3; c++) begin
      diff5[c] = $signed({1'b0, bgc[c]}) - $signed({1'b0, keyc[c]});
      v5_d[c]  = $signed(VW'(fgc[c]) << F) + $signed({1'b0, om4_q}) * diff5[c];
    end
  end

  // Stage 6: round half up and saturate to 0..255.
  logic signed [VW-1:0] r6 [3];
  logic [7:0]           ch6 [3];
  ckcp_pkg::pix_out_t   out6_d, out6_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r6[c] = (v5_q[c] + Half) >>> F;
      if (v5_q[c][VW-1]) begin
        ch6[c] = 8'd0;
      end else if (|r6[c][VW-1:8]) begin
        ch6[c] = 8'd255;
      end else begin
        ch6[c] = r6[c][7:0];
      end
    end
    out6_d.out_blue  = ch6[0];
    out6_d.out_green = ch6[1];
    out6_d.out_red   = ch6[2];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pix1_q <= pix_in_i.data;
      d1_q   <= d1_d;
    end
    if (en[2]) begin
      pix2_q  <= pix1_q;
      prod2_q <= prod2_d;
    end
    if (en[3]) begin
      pix3_q <= pix2_q;
      idx3_q <= idx3_d;
    end
    if (en[4]) begin
      pix4_q <= pix3_q;
      om4_q  <= om4_d;
    end
    if (en[5]) begin
      v5_q <= v5_d;
    end
    if (en[6]) begin
      out6_q <= out6_d;
    end
  end

  assign pix_out_o.valid = vld_q[6];
  assign pix_out_o.data  = out6_q;

endmodule

// ===== rtl/core/ckcp_checker.sv =====
// Port-level checker for the chroma key compositor and its bind statement.
// Depends on ckcp_pkg and chroma_key_composite_pixel.
module ckcp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ckcp_pkg::pix_out_t out_data_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("Output pixel changed while stalled.");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("Input stalled while the output side is free.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_i)
    else $error("Pixel not delivered six cycles after its transfer in.");

endmodule

bind chroma_key_composite_pixel ckcp_checker u_ckcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in_i.valid),
  .in_ready_i  (pix_in_i.ready),
  .out_valid_i (pix_out_o.valid),
  .out_ready_i (pix_out_o.ready),
  .out_data_i  (pix_out_o.data)
);

// ===== test/chroma_key_composite_pixel_test.sv =====
// Self-checking testbench for chroma_key_composite_pixel: drives pixel pairs and register writes,
// predicts pixels in its own fixed-point model or takes typed results, and checks each transfer.
// Depends on ckcp_pkg, the ckcp_intf channel interfaces and the block itself.
`timescale 1ns / 1ps

module chroma_key_composite_pixel_test;

  localparam int ClkPeriod = 8;
  localparam int PipeDepth = 6;
  localparam int LutSize   = ckcp_pkg::SigTableEntries;
  localparam int FracBits  = ckcp_pkg::AlphaFracBits;
  localparam longint unsigned QOne = 64'h8000_0000;

  typedef struct packed {
    logic [7:0]  key_blue;
    logic [7:0]  key_green;
    logic [7:0]  key_red;
    logic [9:0]  blue_gain;
    logic [15:0] alpha_scale;
  } matte_regs_t;

  typedef struct packed {
    matte_regs_t        regs;
    ckcp_pkg::pix_in_t  pix;
    logic               fixed;
    ckcp_pkg::pix_out_t want;
  } plan_row_t;

  localparam matte_regs_t RegsRst =
    '{ckcp_pkg::KeyBlueRst, ckcp_pkg::KeyGreenRst, ckcp_pkg::KeyRedRst,
      ckcp_pkg::BlueGainRst, ckcp_pkg::AlphaScaleRst};
  localparam matte_regs_t RegsWhite = '{8'd255, 8'd255, 8'd255, 10'd0, 16'd257};
  localparam matte_regs_t RegsSteep = '{8'd0, 8'd255, 8'd0, 10'd0, 16'd65535};
  localparam matte_regs_t RegsHard  = '{8'd0, 8'd255, 8'd0, 10'd1023, 16'd65535};
  localparam matte_regs_t RegsFlat  = '{8'd0, 8'd255, 8'd0, 10'd325, 16'd0};
  localparam matte_regs_t RegsZero  = '{8'd0, 8'd0, 8'd0, 10'd0, 16'd0};
  localparam matte_regs_t RegsFull  = '{8'd255, 8'd255, 8'd255, 10'd1023, 16'd65535};

  // Rows with a typed result sit on a fully keyed or fully opaque alpha; the rest are predicted.
  localparam plan_row_t Plan [16] = '{
    '{RegsRst, '{8'd0, 8'd255, 8'd0, 8'd12, 8'd34, 8'd56}, 1'b1, '{8'd12, 8'd34, 8'd56}},
    '{RegsRst, '{8'd0, 8'd0, 8'd77, 8'd200, 8'd100, 8'd50}, 1'b1, '{8'd0, 8'd0, 8'd77}},
    '{RegsRst, '{8'd0, 8'd255, 8'd200, 8'd10, 8'd20, 8'd100}, 1'b1, '{8'd10, 8'd20, 8'd255}},
    '{RegsRst, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{RegsRst, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255}},
    '{RegsRst, '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b1, '{8'd255, 8'd0, 8'd255}},
    '{RegsRst, '{8'd60, 8'd180, 8'd70, 8'd30, 8'd90, 8'd200}, 1'b0, '0},
    '{RegsRst, '{8'd10, 8'd240, 8'd20, 8'd255, 8'd0, 8'd128}, 1'b0, '0},
    '{RegsRst, '{8'd128, 8'd128, 8'd128, 8'd64, 8'd64, 8'd64}, 1'b0, '0},
    '{RegsRst, '{8'd40, 8'd200, 8'd40, 8'd200, 8'd40, 8'd200}, 1'b0, '0},
    '{RegsWhite, '{8'd0, 8'd255, 8'd0, 8'd0, 8'd40, 8'd10}, 1'b1, '{8'd0, 8'd40, 8'd0}},
    '{RegsWhite, '{8'd200, 8'd230, 8'd180, 8'd20, 8'd30, 8'd40}, 1'b0, '0},
    '{RegsSteep, '{8'd0, 8'd255, 8'd0, 8'd90, 8'd91, 8'd92}, 1'b1, '{8'd90, 8'd91, 8'd92}},
    '{RegsSteep, '{8'd50, 8'd200, 8'd60, 8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{RegsHard, '{8'd255, 8'd0, 8'd128, 8'd1, 8'd2, 8'd3}, 1'b1, '{8'd255, 8'd0, 8'd128}},
    '{RegsFlat, '{8'd17, 8'd255, 8'd3, 8'd250, 8'd250, 8'd250}, 1'b1, '{8'd17, 8'd255, 8'd3}}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [ckcp_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [ckcp_pkg::CfgDataW-1:0] cfg_wdata;

  ckcp_in_if  pix_in ();
  ckcp_out_if pix_out ();

  chroma_key_composite_pixel i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_in_i    (pix_in),
    .pix_out_o   (pix_out)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  matte_regs_t        matte;
  longint unsigned    alpha_lut [LutSize];
  ckcp_pkg::pix_out_t expected_pixels [$];
  int                 n_errors = 0;
  bit                 source_calm = 1'b0;
  bit                 sink_calm = 1'b0;
  int                 stall_left = 0;

  // exp(-u) in Q.31: Taylor series at u/16, then four truncating squarings.
  function automatic longint unsigned decay_q31(longint unsigned u);
    longint unsigned v;
    longint unsigned term;
    longint unsigned y;
    longint          sum;
    int              k;
    v    = u >> 4;
    term = QOne;
    sum  = longint'(QOne);
    for (k = 1; k <= 20; k++) begin
      term = ((term * v) >> 31) / longint'(k);
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(QOne)) begin
      sum = longint'(QOne);
    end
    y = longint'(sum);
    for (k = 0; k < 4; k++) begin
      y = (y * y) >> 31;
    end
    return y;
  endfunction

  task automatic build_alpha_lut();
    longint          s;
    longint unsigned mag;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    for (int i = 0; i < LutSize; i++) begin
      s   = 2 * i + 1 - LutSize;
      mag = (s < 0) ? -s : s;
      e   = decay_q31((mag * 20 * QOne) / longint'(2 * LutSize));
      num = (s >= 0) ? QOne : e;
      den = QOne + e;
      alpha_lut[i] = ((num << FracBits) + den / 2) / den;
    end
  endtask

  function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] key,
                                             longint om);
    longint v;
    longint r;
    v = longint'(fg) * (longint'(1) << FracBits) - om * longint'(key) + longint'(bg) * om;
    if (v < 0) begin
      return 8'd0;
    end
    r = (v + (longint'(1) << (FracBits - 1))) >>> FracBits;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic ckcp_pkg::pix_out_t predict_composite(ckcp_pkg::pix_in_t p);
    longint             m;
    longint             d;
    longint             raw;
    longint             idx;
    longint             om;
    ckcp_pkg::pix_out_t res;
    m   = (p.fg_green < matte.key_green) ? longint'(p.fg_green) : longint'(matte.key_green);
    d   = m * 256 - longint'(matte.blue_gain) * longint'(p.fg_blue);
    raw = 4096 - ((longint'(matte.alpha_scale) * d + 2048) >>> 12);
    if (raw > 32767) begin
      raw = 32767;
    end
    if (raw < -32768) begin
      raw = -32768;
    end
    if (raw < 0) begin
      idx = 0;
    end else if (raw >= 4096) begin
      idx = LutSize - 1;
    end else begin
      idx = (raw * LutSize) / 4096;
    end
    om = (longint'(1) << FracBits) - longint'(alpha_lut[idx]);
    res.out_blue  = mix_channel(p.fg_blue, p.bg_blue, matte.key_blue, om);
    res.out_green = mix_channel(p.fg_green, p.bg_green, matte.key_green, om);
    res.out_red   = mix_channel(p.fg_red, p.bg_red, matte.key_red, om);
    return res;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  task automatic note_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_channel(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic write_reg(logic [ckcp_pkg::CfgIdxW-1:0] idx,
                           logic [ckcp_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      ckcp_pkg::CfgKeyBlue:    matte.key_blue    = data[7:0];
      ckcp_pkg::CfgKeyGreen:   matte.key_green   = data[7:0];
      ckcp_pkg::CfgKeyRed:     matte.key_red     = data[7:0];
      ckcp_pkg::CfgBlueGain:   matte.blue_gain   = data[9:0];
      ckcp_pkg::CfgAlphaScale: matte.alpha_scale = data;
      default: ;
    endcase
  endtask

  // Program a new key setting once the pipeline has drained; one write also hits an unmapped index.
  task automatic load_matte(matte_regs_t r);
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    write_reg(ckcp_pkg::CfgKeyBlue, ckcp_pkg::CfgDataW'(r.key_blue));
    write_reg(ckcp_pkg::CfgKeyGreen, ckcp_pkg::CfgDataW'(r.key_green));
    write_reg(ckcp_pkg::CfgKeyRed, ckcp_pkg::CfgDataW'(r.key_red));
    write_reg(ckcp_pkg::CfgBlueGain, ckcp_pkg::CfgDataW'(r.blue_gain));
    write_reg(ckcp_pkg::CfgIdxW'($urandom_range(2 ** ckcp_pkg::CfgIdxW - 1,
                                                int'(ckcp_pkg::CfgAlphaScale) + 1)),
              ckcp_pkg::CfgDataW'($urandom));
    write_reg(ckcp_pkg::CfgAlphaScale, r.alpha_scale);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(ckcp_pkg::pix_in_t p, logic fixed, ckcp_pkg::pix_out_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      source_calm = !source_calm;
    end
    gap = pick_gap(source_calm);
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= p;
    do begin
      @(posedge clk_i);
    end while (!pix_in.ready);
    expected_pixels.push_back(fixed ? want : predict_composite(p));
  endtask

  function automatic matte_regs_t draw_matte();
    matte_regs_t r;
    int          den;
    r.key_blue  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 60)) : 8'($urandom);
    r.key_green = 8'($urandom_range(120, 255));
    r.key_red   = 8'($urandom);
    r.blue_gain = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(280, 370)) : 10'($urandom);
    den = int'(r.key_green) * 256 - int'(r.blue_gain) * int'(r.key_blue);
    if (den > 256 && $urandom_range(0, 4) != 0) begin
      r.alpha_scale = 16'((1 << 24) / den);
    end else begin
      r.alpha_scale = 16'($urandom);
    end
    return r;
  endfunction

  function automatic logic [7:0] toward_key(logic [7:0] key);
    int w;
    int v;
    w = $urandom_range(0, 16);
    v = (int'(key) * w + $urandom_range(0, 255) * (16 - w)) / 16 + $urandom_range(0, 8) - 4;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Most pixels are mixes of the key color and a random color, so alpha sweeps its range.
  function automatic ckcp_pkg::pix_in_t draw_pixel();
    ckcp_pkg::pix_in_t p;
    p = ckcp_pkg::pix_in_t'(48'({$urandom, $urandom}));
    if ($urandom_range(0, 9) >= 4) begin
      p.fg_blue  = toward_key(matte.key_blue);
      p.fg_green = toward_key(matte.key_green);
      p.fg_red   = toward_key(matte.key_red);
    end
    return p;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("composited pixel with no pixel outstanding");
      end else begin
        check_channel("out_blue", pix_out.data.out_blue, expected_pixels[0].out_blue);
        check_channel("out_green", pix_out.data.out_green, expected_pixels[0].out_green);
        check_channel("out_red", pix_out.data.out_red, expected_pixels[0].out_red);
        void'(expected_pixels.pop_front());
      end
    end
  end

  initial begin
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) begin
        sink_calm = !sink_calm;
      end
      if (stall_left != 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
        stall_left = pick_gap(sink_calm);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= ckcp_pkg::CfgKeyBlue;
    cfg_wdata    <= '0;
    pix_in.valid <= 1'b0;
    pix_in.data  <= '0;
    matte = RegsRst;
    build_alpha_lut();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Plan[i]) begin
      if (Plan[i].regs != matte) begin
        load_matte(Plan[i].regs);
      end
      send_pixel(Plan[i].pix, Plan[i].fixed, Plan[i].want);
    end

    for (int ph = 0; ph < 9; ph++) begin
      load_matte((ph == 0) ? RegsZero : (ph == 1) ? RegsFull : draw_matte());
      repeat (55) send_pixel(draw_pixel(), 1'b0, '0);
    end

    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4 * PipeDepth) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
